[hw/rtl/fgpp_pkg.sv]
// Shared constants, request codes and font lookup for the glyph page plotter.
`default_nettype none

package fgpp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  // wide enough for page * width + column at any supported display size
  localparam int unsigned LIN_W     = 13;
  // column plus glyph width, compared against a width of up to 256
  localparam int unsigned EDGE_W    = 9;

  typedef logic [1:0] req_t;
  localparam req_t REQ_DRAW  = 2'd0;
  localparam req_t REQ_CLEAR = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  typedef logic [5:0] glyph_idx_t;
  localparam glyph_idx_t GI_BLANK   = 6'd0;
  localparam glyph_idx_t GI_DIGIT   = 6'd1;
  localparam glyph_idx_t GI_LETTER  = 6'd11;
  localparam glyph_idx_t GI_MINUS   = 6'd37;
  localparam glyph_idx_t GI_COLON   = 6'd38;
  localparam glyph_idx_t GI_DOT     = 6'd39;
  localparam glyph_idx_t GI_PERCENT = 6'd40;
  localparam glyph_idx_t GI_SLASH   = 6'd41;
  localparam int unsigned GI_COUNT  = 42;

  // one glyph per entry, leftmost column in the top byte
  localparam logic [39:0] FONT_ROM [GI_COUNT] = '{
    40'h00_00_00_00_00,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
    40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
    40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
    40'h06_49_49_29_1E,
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01,
    40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
    40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
    40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
    40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43,
    40'h08_08_08_08_08,
    40'h00_36_36_00_00,
    40'h00_60_60_00_00,
    40'h23_13_08_64_62,
    40'h20_10_08_04_02
  };

  // ASCII to font entry; lower case folds onto upper case
  function automatic glyph_idx_t glyph_index(input logic [7:0] code);
    logic [7:0] c;
    glyph_idx_t gi;
    c  = code;
    gi = GI_BLANK;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    if (code >= 8'h30 && code <= 8'h39) begin
      gi = GI_DIGIT + glyph_idx_t'(code - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      gi = GI_LETTER + glyph_idx_t'(c - 8'h41);
    end else begin
      unique case (c)
        8'h2D:   gi = GI_MINUS;
        8'h3A:   gi = GI_COLON;
        8'h2E:   gi = GI_DOT;
        8'h25:   gi = GI_PERCENT;
        8'h2F:   gi = GI_SLASH;
        default: gi = GI_BLANK;
      endcase
    end
    return gi;
  endfunction

  function automatic logic [BYTE_W-1:0] font_col(input glyph_idx_t gi, input logic [2:0] col);
    logic [39:0] g;
    logic [BYTE_W-1:0] b;
    g = '0;
    b = '0;
    if (32'(gi) < GI_COUNT) g = FONT_ROM[gi];
    unique case (col)
      3'd0:    b = g[39:32];
      3'd1:    b = g[31:24];
      3'd2:    b = g[23:16];
      3'd3:    b = g[15:8];
      3'd4:    b = g[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fgpp_frame_ram.sv]
// Frame store: one write port, one registered read port.
`default_nettype none

module fgpp_frame_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [fgpp_pkg::BYTE_W-1:0]   wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [fgpp_pkg::BYTE_W-1:0]   rdata
);

  logic [fgpp_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/font_glyph_page_plotter_core.sv]
// Top level: 5x7 glyph plotter over a page-organised monochrome frame store.
//
//  channel | direction | ports                                         | handshake
//  --------+-----------+-----------------------------------------------+------------------
//  in_     | input     | req_type, x_pos, y_pos, char_code, read_address | in_valid/in_ready
//  out_    | output    | read_data                                     | out_valid/out_ready
//
// Draw: ten read-modify-write slots (five columns, two pages each) pipelined
//   through the registered RAM read port.
// Read: the RAM read issues at accept, then the byte waits in the output register.
// Clear: one byte zeroed per cycle across the whole store.
// After reset the same zeroing sweep runs (in_ready low).
// One item in flight at a time; a read item stalls only if the previous
// result is still unclaimed.
`default_nettype none

module font_glyph_page_plotter_core #(
  parameter int unsigned DISPLAY_WIDTH  = 128,
  parameter int unsigned DISPLAY_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [6:0]  in_x_pos,
  input  wire logic [5:0]  in_y_pos,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [9:0]  in_read_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_data
);

  localparam int unsigned PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int unsigned STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam int unsigned SLOTS       = 2 * fgpp_pkg::GLYPH_COLS;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic [6:0]  x_r, x_nxt;
  logic [5:0]  y_r, y_nxt;
  fgpp_pkg::glyph_idx_t gi_r, gi_nxt;
  logic        oor_r, oor_nxt;

  logic        wr_pend_r;
  logic [AW-1:0] wr_addr_r;
  logic [7:0]  wr_mask_r;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  logic        in_fire;
  logic        draw_drop;
  logic [2:0]  col;
  logic        half;
  logic [15:0] shifted;
  logic [7:0]  slot_mask;
  logic [3:0]  page;
  logic [fgpp_pkg::LIN_W-1:0] lin;
  logic        issue;

  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // glyph must sit wholly inside the display, edge row and column excluded
  assign draw_drop =
      ((fgpp_pkg::EDGE_W'(in_x_pos) + fgpp_pkg::EDGE_W'(fgpp_pkg::GLYPH_COLS))
         >= fgpp_pkg::EDGE_W'(DISPLAY_WIDTH)) ||
      ((fgpp_pkg::EDGE_W'(in_y_pos) + fgpp_pkg::EDGE_W'(fgpp_pkg::GLYPH_ROWS))
         >= fgpp_pkg::EDGE_W'(DISPLAY_HEIGHT));

  // slot decode: column in the upper bits, page half in bit 0
  always_comb begin
    col       = slot_r[3:1];
    half      = slot_r[0];
    shifted   = {8'd0, fgpp_pkg::font_col(gi_r, col)} << y_r[2:0];
    slot_mask = half ? shifted[15:8] : shifted[7:0];
    page      = {1'b0, y_r[5:3]} + {3'd0, half};
    lin       = fgpp_pkg::LIN_W'(page) * fgpp_pkg::LIN_W'(DISPLAY_WIDTH)
              + fgpp_pkg::LIN_W'(x_r) + fgpp_pkg::LIN_W'(col);
    // empty slots skip the access, so a page past the bottom is never touched
    issue     = (state_r == ST_DRAW) && (slot_r < 4'(SLOTS)) && (slot_mask != 8'd0);
  end

  // RAM ports: the clear sweep and the draw write-back never overlap
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_r;
    ram_wdata = ram_rdata | wr_mask_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = 8'd0;
    end else if (wr_pend_r) begin
      ram_we    = 1'b1;
    end
    ram_re    = issue || (in_fire && (in_req_type == fgpp_pkg::REQ_READ));
    ram_raddr = issue ? AW'(lin) : AW'(in_read_address);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    gi_nxt        = gi_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_req_type)
            fgpp_pkg::REQ_DRAW: begin
              if (!draw_drop) begin
                state_nxt = ST_DRAW;
                slot_nxt  = 4'd0;
                x_nxt     = in_x_pos;
                y_nxt     = in_y_pos;
                gi_nxt    = fgpp_pkg::glyph_index(in_char_code);
              end
            end
            fgpp_pkg::REQ_CLEAR: begin
              state_nxt = ST_CLEAR;
              clr_nxt   = '0;
            end
            fgpp_pkg::REQ_READ: begin
              state_nxt = ST_READ;
              oor_nxt   = fgpp_pkg::LIN_W'(in_read_address)
                          >= fgpp_pkg::LIN_W'(STORE_BYTES);
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(STORE_BYTES - 1)) state_nxt = ST_IDLE;
      end
      ST_DRAW: begin
        // the last slot's write-back lands in the closing cycle
        slot_nxt = slot_r + 4'd1;
        if (slot_r == 4'(SLOTS)) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        // RAM data holds while the output register is still occupied
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = oor_r ? 8'd0 : ram_rdata;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      slot_r      <= 4'd0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    gi_r       <= gi_nxt;
    oor_r      <= oor_nxt;
    out_data_r <= out_data_nxt;
    wr_addr_r  <= AW'(lin);
    wr_mask_r  <= slot_mask;
  end

  fgpp_frame_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[bench/font_glyph_page_plotter_core_tb.sv]
// Self-checking testbench for font_glyph_page_plotter_core: draws, clears and reads vs a shadow store.
`default_nettype none

module font_glyph_page_plotter_core_tb;

  // display geometry, matched to the instance below
  localparam int DISP_W      = 128;
  localparam int DISP_H      = 64;
  localparam int PAGES       = (DISP_H + 7) / 8;
  localparam int FRAME_BYTES = DISP_W * PAGES;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_ITEMS  = 410;
  // long receiver hold-off, enough for the block to back up on a second read
  localparam int HOLD_CYCLES  = 400;
  // a clear sweeps the whole store one byte a cycle; let any last one finish
  localparam int TAIL_CYCLES  = FRAME_BYTES + 80;
  // worst quiet stretch is the post-reset sweep or a clear plus a sender gap;
  // several times that
  localparam int STALL_LIMIT  = 6000;
  localparam int MAX_PRINTS   = 100;

  // request code the block must ignore
  localparam fgpp_pkg::req_t REQ_NONE = 2'd3;

  // font slots
  localparam int SLOT_BLANK   = 0;
  localparam int SLOT_DIGIT   = 1;
  localparam int SLOT_LETTER  = 11;
  localparam int SLOT_MINUS   = 37;
  localparam int SLOT_COLON   = 38;
  localparam int SLOT_DOT     = 39;
  localparam int SLOT_PERCENT = 40;
  localparam int SLOT_SLASH   = 41;
  localparam int SLOT_COUNT   = 42;

  // 5x7 glyphs, leftmost column in the top byte, bit 0 of a column is the top row
  localparam logic [39:0] GLYPH_BITS [SLOT_COUNT] = '{
    40'h0000000000,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543,
    40'h0808080808,
    40'h0036360000,
    40'h0060600000,
    40'h2313086462,
    40'h2010080402
  };

  // one row of the directed plan; want is used only where typed is set
  typedef struct packed {
    fgpp_pkg::req_t req;
    logic [6:0]     x;
    logic [5:0]     y;
    logic [7:0]     code;
    logic [9:0]     addr;
    logic           typed;
    logic [7:0]     want;
  } stim_row_t;

  localparam int PLAN_ROWS = 25;
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    // store must be blank straight out of reset, first and last byte
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd0,    1'b1, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd1023, 1'b1, 8'h00},
    // '0' at the top left corner
    '{fgpp_pkg::REQ_DRAW,  7'd0,   6'd0,  8'h30, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd0,    1'b1, 8'h3E},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd2,    1'b1, 8'h49},
    // 'A' touching the right edge: dropped
    '{fgpp_pkg::REQ_DRAW,  7'd123, 6'd0,  8'h41, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd123,  1'b1, 8'h00},
    // 'W' touching the bottom edge: dropped
    '{fgpp_pkg::REQ_DRAW,  7'd10,  6'd57, 8'h57, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd906,  1'b1, 8'h00},
    // lower case 'z' in the furthest corner that still fits
    '{fgpp_pkg::REQ_DRAW,  7'd122, 6'd56, 8'h7A, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd1018, 1'b0, 8'h00},
    // '%' straddling pages 0 and 1
    '{fgpp_pkg::REQ_DRAW,  7'd20,  6'd3,  8'h25, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd148,  1'b0, 8'h00},
    // punctuation row on page 1, then a code with no glyph
    '{fgpp_pkg::REQ_DRAW,  7'd30,  6'd8,  8'h2D, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_DRAW,  7'd36,  6'd8,  8'h3A, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_DRAW,  7'd42,  6'd8,  8'h2E, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_DRAW,  7'd48,  6'd8,  8'h2F, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_DRAW,  7'd54,  6'd8,  8'hFF, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd160,  1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd177,  1'b0, 8'h00},
    // unused request code with every field at its top
    '{REQ_NONE,            7'd127, 6'd63, 8'hFF, 10'd1023, 1'b0, 8'h00},
    // both coordinates at their maxima: dropped
    '{fgpp_pkg::REQ_DRAW,  7'd127, 6'd63, 8'h38, 10'd0,    1'b0, 8'h00},
    // clear wipes what was drawn
    '{fgpp_pkg::REQ_CLEAR, 7'd0,   6'd0,  8'h00, 10'd0,    1'b0, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd0,    1'b1, 8'h00},
    '{fgpp_pkg::REQ_READ,  7'd0,   6'd0,  8'h00, 10'd160,  1'b1, 8'h00}
  };

  // idle mix per phase: free-running, sender gaps, receiver stalls, both
  localparam int SND_PCT [4] = '{0, 69, 0, 18};
  localparam int RCV_PCT [4] = '{0, 0, 69, 18};

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  fgpp_pkg::req_t in_req_type;
  logic [6:0]     in_x_pos;
  logic [5:0]     in_y_pos;
  logic [7:0]     in_char_code;
  logic [9:0]     in_read_address;
  logic           out_valid;
  logic           out_ready;
  logic [7:0]     out_read_data;

  // shadow copy of the frame store and the bytes that reads still owe us
  logic [7:0] pixel_bytes [FRAME_BYTES];
  logic [7:0] reads_due [$];

  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  holds_done = 0;
  int  mismatches = 0;
  int  reads_matched = 0;
  int  n_draws = 0, n_dropped = 0, n_clears = 0, n_reads = 0, n_unused = 0;
  int  last_x = 0, last_y = 0;
  string charset = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-:.%/";

  font_glyph_page_plotter_core #(
    .DISPLAY_WIDTH  (DISP_W),
    .DISPLAY_HEIGHT (DISP_H)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_x_pos        (in_x_pos),
    .in_y_pos        (in_y_pos),
    .in_char_code    (in_char_code),
    .in_read_address (in_read_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    // keep the log bounded if the block is badly off
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // ASCII to font slot; lower case folds onto upper case, unknown codes are blank
  function automatic int font_slot(input logic [7:0] code);
    logic [7:0] c;
    int slot;
    c    = code;
    slot = SLOT_BLANK;
    if (c >= "0" && c <= "9") begin
      slot = SLOT_DIGIT + int'(c - "0");
    end else begin
      if (c >= "a" && c <= "z") c = c - 8'd32;
      if (c >= "A" && c <= "Z") slot = SLOT_LETTER + int'(c - "A");
      else if (c == "-") slot = SLOT_MINUS;
      else if (c == ":") slot = SLOT_COLON;
      else if (c == ".") slot = SLOT_DOT;
      else if (c == "%") slot = SLOT_PERCENT;
      else if (c == "/") slot = SLOT_SLASH;
    end
    return slot;
  endfunction

  // Applies one item to the shadow store; returns 1 when the item yields a byte.
  function automatic bit predict_request(input fgpp_pkg::req_t req, input logic [6:0] x,
                                         input logic [5:0] y, input logic [7:0] code,
                                         input logic [9:0] addr, output logic [7:0] rd_byte);
    logic [39:0] g;
    logic [7:0]  colbits;
    int          col, row, py, idx;
    rd_byte = '0;
    case (req)
      fgpp_pkg::REQ_DRAW: begin
        // glyph must sit wholly inside the display, else nothing is plotted
        if (int'(x) + 5 >= DISP_W || int'(y) + 7 >= DISP_H) begin
          n_dropped++;
          return 1'b0;
        end
        g = GLYPH_BITS[font_slot(code)];
        for (col = 0; col < 5; col++) begin
          colbits = g[39 - 8*col -: 8];
          for (row = 0; row < 7; row++) begin
            if (colbits[row]) begin
              py  = int'(y) + row;
              idx = (py / 8) * DISP_W + int'(x) + col;
              if (idx < FRAME_BYTES) pixel_bytes[idx][py % 8] = 1'b1;
            end
          end
        end
        return 1'b0;
      end
      fgpp_pkg::REQ_CLEAR: begin
        foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
        return 1'b0;
      end
      fgpp_pkg::REQ_READ: begin
        rd_byte = (int'(addr) < FRAME_BYTES) ? pixel_bytes[addr] : 8'h00;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item, waits for it to be taken, then books what it should yield.
  // Valid is only dropped during a gap before the item, never once raised.
  task automatic send_item(input fgpp_pkg::req_t req, input logic [6:0] x,
                           input logic [5:0] y, input logic [7:0] code,
                           input logic [9:0] addr,
                           input logic typed, input logic [7:0] want);
    logic [7:0] rd_byte;
    bit         yields;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_x_pos        <= x;
    in_y_pos        <= y;
    in_char_code    <= code;
    in_read_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (req)
      fgpp_pkg::REQ_DRAW:  n_draws++;
      fgpp_pkg::REQ_CLEAR: n_clears++;
      fgpp_pkg::REQ_READ:  n_reads++;
      default:             n_unused++;
    endcase
    yields = predict_request(req, x, y, code, addr, rd_byte);
    // directed rows with a hand-worked answer use it instead of the shadow
    if (yields) reads_due.push_back(typed ? want : rd_byte);
  endtask

  // Mostly legal glyphs and reads near the last glyph, so reads see real pixels;
  // the rest is edge drops, unused codes, clears and raw noise.
  task automatic random_item();
    int unsigned    pick;
    int             page;
    fgpp_pkg::req_t req;
    logic [6:0]     x;
    logic [5:0]     y;
    logic [7:0]     code;
    logic [9:0]     addr;
    pick = $urandom_range(99);
    req  = fgpp_pkg::REQ_DRAW;
    x    = 7'($urandom_range(127));
    y    = 6'($urandom_range(63));
    code = 8'($urandom_range(255));
    addr = 10'($urandom_range(1023));
    if (pick < 48) begin
      x = 7'($urandom_range(122));
      y = 6'($urandom_range(56));
      if ($urandom_range(9) != 0) code = charset[$urandom_range(charset.len() - 1)];
      last_x = int'(x);
      last_y = int'(y);
    end else if (pick < 90) begin
      req = fgpp_pkg::REQ_READ;
      if ($urandom_range(9) < 6) begin
        page = last_y / 8 + int'($urandom_range(1));
        addr = 10'(page * DISP_W + last_x + int'($urandom_range(4)));
      end
    end else if (pick < 93) begin
      // right or bottom edge: must be dropped
      if ($urandom_range(1) != 0) x = 7'($urandom_range(127, 123));
      else                        y = 6'($urandom_range(63, 57));
    end else if (pick < 96) begin
      req = REQ_NONE;
    end else if (pick < 97) begin
      req = fgpp_pkg::REQ_CLEAR;
    end else begin
      req = fgpp_pkg::req_t'($urandom_range(3));
    end
    send_item(req, x, y, code, addr, 1'b0, 8'h00);
  endtask

  // Receiver: random back-pressure per phase, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      out_ready <= ($urandom_range(99) < rcv_stall_pct) ? 1'b0 : 1'b1;
    end
  end

  // Result checker: each byte taken against the oldest one owed.
  initial begin
    logic [7:0] want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (reads_due.size() == 0) begin
          report_mismatch($sformatf("result %02h with no read outstanding", out_read_data));
        end else begin
          want = reads_due.pop_front();
          if (out_read_data !== want)
            report_mismatch($sformatf("read_data got %02h want %02h", out_read_data, want));
          else
            reads_matched++;
        end
      end
    end
  end

  // Watchdog: quiet cycles on both channels; any handshake restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("TIMEOUT: no item moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence: reset, directed plan, four random phases, drain.
  initial begin
    int phase;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = fgpp_pkg::REQ_DRAW;
    in_x_pos        = '0;
    in_y_pos        = '0;
    in_char_code    = '0;
    in_read_address = '0;
    foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // the block sweeps its store after reset; send_item simply waits on ready
    foreach (PLAN[i])
      send_item(PLAN[i].req, PLAN[i].x, PLAN[i].y, PLAN[i].code, PLAN[i].addr,
                PLAN[i].typed, PLAN[i].want);

    for (phase = 0; phase < 4; phase++) begin
      snd_idle_pct  = SND_PCT[phase];
      rcv_stall_pct = RCV_PCT[phase];
      // first phase opens with the receiver held off while items keep coming
      if (phase == 0) hold_req = 1'b1;
      repeat (PHASE_ITEMS) random_item();
    end
    in_valid <= 1'b0;
    rcv_stall_pct = 0;

    while (reads_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d draws (%0d off the edge), %0d clears, %0d reads, %0d unused codes",
             n_draws, n_dropped, n_clears, n_reads, n_unused);
    $display("Run: %0d read bytes matched, %0d long receiver hold-off(s), %0d mismatches",
             reads_matched, holds_done, mismatches);
    if (mismatches == 0 && reads_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
